### hdl/bt_pkg.sv
// ----------------------------------------------------------------------------
// bt_pkg: shared types and constants for the modular product pipeline
// Holds operand widths, register indexes and the stage control struct.
// ----------------------------------------------------------------------------
package bt_pkg;

    // raw operand width: every input value is two 64-bit halves
    localparam int unsigned SRC_WIDTH   = 128;
    localparam int unsigned HALF_WIDTH  = 64;
    localparam int unsigned DEF_MOD_WIDTH = 128;

    // configuration register indexes
    localparam logic REG_MOD_LOW  = 1'b0;
    localparam logic REG_MOD_HIGH = 1'b1;

    // control travelling with each transaction along the chain
    typedef struct packed {
        logic valid;
        logic zero_mod;
    } t_ctl;

endpackage

### hdl/bt_red_cell.sv
// ----------------------------------------------------------------------------
// bt_red_cell: one step of the shift-subtract reduction
// Shifts one source bit into each of three remainders (x, a, c) and
// subtracts p when needed; y and b ride along unchanged.
// ----------------------------------------------------------------------------
module bt_red_cell
    import bt_pkg::*;
#(
    parameter int unsigned MOD_WIDTH = DEF_MOD_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [MOD_WIDTH-1:0]          i_p,
    input  t_ctl                          i_ctl,
    input  logic [2:0][SRC_WIDTH-1:0]     i_src,
    input  logic [2:0][MOD_WIDTH-1:0]     i_rem,
    input  logic [1:0][SRC_WIDTH-1:0]     i_pass,
    output t_ctl                          o_ctl,
    output logic [2:0][SRC_WIDTH-1:0]     o_src,
    output logic [2:0][MOD_WIDTH-1:0]     o_rem,
    output logic [1:0][SRC_WIDTH-1:0]     o_pass
);

    t_ctl                      r_ctl;
    logic [2:0][SRC_WIDTH-1:0] r_src;
    logic [2:0][MOD_WIDTH-1:0] r_rem;
    logic [1:0][SRC_WIDTH-1:0] r_pass;
    logic [2:0][MOD_WIDTH-1:0] n_rem;
    logic [2:0][SRC_WIDTH-1:0] n_src;

    // one reduction step per lane: remainder stays below p
    always_comb begin
        logic [MOD_WIDTH:0] sh;
        for (int k = 0; k < 3; k++) begin
            sh = {i_rem[k], i_src[k][SRC_WIDTH-1]};
            if (sh >= {1'b0, i_p}) begin
                sh = sh - {1'b0, i_p};
            end
            n_rem[k] = sh[MOD_WIDTH-1:0];
            n_src[k] = {i_src[k][SRC_WIDTH-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_src  <= n_src;
            r_rem  <= n_rem;
            r_pass <= i_pass;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_src  = r_src;
    assign o_rem  = r_rem;
    assign o_pass = r_pass;

endmodule

### hdl/bt_mul_cell.sv
// ----------------------------------------------------------------------------
// bt_mul_cell: one step of the double-and-add modular multiply
// Two lanes (x*y and a*b); each takes the top multiplier bit, doubles the
// accumulator and adds the multiplicand, then folds back below p.
// ----------------------------------------------------------------------------
module bt_mul_cell
    import bt_pkg::*;
#(
    parameter int unsigned MOD_WIDTH = DEF_MOD_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [MOD_WIDTH-1:0]          i_p,
    input  t_ctl                          i_ctl,
    input  logic [1:0][MOD_WIDTH-1:0]     i_mcand,
    input  logic [1:0][SRC_WIDTH-1:0]     i_mplier,
    input  logic [1:0][MOD_WIDTH-1:0]     i_acc,
    input  logic [MOD_WIDTH-1:0]          i_c,
    output t_ctl                          o_ctl,
    output logic [1:0][MOD_WIDTH-1:0]     o_mcand,
    output logic [1:0][SRC_WIDTH-1:0]     o_mplier,
    output logic [1:0][MOD_WIDTH-1:0]     o_acc,
    output logic [MOD_WIDTH-1:0]          o_c
);

    t_ctl                      r_ctl;
    logic [1:0][MOD_WIDTH-1:0] r_mcand;
    logic [1:0][SRC_WIDTH-1:0] r_mplier;
    logic [1:0][MOD_WIDTH-1:0] r_acc;
    logic [MOD_WIDTH-1:0]      r_c;
    logic [1:0][MOD_WIDTH-1:0] n_acc;

    // t = 2*acc + bit*mcand < 3p; subtract 0, p or 2p
    always_comb begin
        logic [MOD_WIDTH+1:0] t;
        logic [MOD_WIDTH+1:0] p1;
        logic [MOD_WIDTH+1:0] p2;
        p1 = {2'b00, i_p};
        p2 = {1'b0, i_p, 1'b0};
        for (int k = 0; k < 2; k++) begin
            t = {1'b0, i_acc[k], 1'b0}
                + (i_mplier[k][SRC_WIDTH-1] ? {2'b00, i_mcand[k]} : '0);
            if (t >= p2) begin
                t = t - p2;
            end else if (t >= p1) begin
                t = t - p1;
            end
            n_acc[k] = t[MOD_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mcand     <= i_mcand;
            r_mplier[0] <= {i_mplier[0][SRC_WIDTH-2:0], 1'b0};
            r_mplier[1] <= {i_mplier[1][SRC_WIDTH-2:0], 1'b0};
            r_acc       <= n_acc;
            r_c         <= i_c;
        end
    end

    assign o_ctl    = r_ctl;
    assign o_mcand  = r_mcand;
    assign o_mplier = r_mplier;
    assign o_acc    = r_acc;
    assign o_c      = r_c;

endmodule

### hdl/bt_final.sv
// ----------------------------------------------------------------------------
// bt_final: closing modular add and subtract
// Forms (c + x*y - a*b) mod p over two register stages.
// ----------------------------------------------------------------------------
module bt_final
    import bt_pkg::*;
#(
    parameter int unsigned MOD_WIDTH = DEF_MOD_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic [MOD_WIDTH-1:0]  i_p,
    input  t_ctl                  i_ctl,
    input  logic [MOD_WIDTH-1:0]  i_c,
    input  logic [MOD_WIDTH-1:0]  i_xy,
    input  logic [MOD_WIDTH-1:0]  i_ab,
    output t_ctl                  o_ctl,
    output logic [MOD_WIDTH-1:0]  o_res
);

    t_ctl                 r_ctl1;
    t_ctl                 r_ctl2;
    logic [MOD_WIDTH-1:0] r_sum;
    logic [MOD_WIDTH-1:0] r_ab;
    logic [MOD_WIDTH-1:0] r_res;
    logic [MOD_WIDTH-1:0] n_sum;
    logic [MOD_WIDTH-1:0] n_res;

    // stage 1: c + xy mod p
    always_comb begin
        logic [MOD_WIDTH:0] t;
        t = {1'b0, i_c} + {1'b0, i_xy};
        if (t >= {1'b0, i_p}) begin
            t = t - {1'b0, i_p};
        end
        n_sum = t[MOD_WIDTH-1:0];
    end

    // stage 2: sum - ab mod p
    always_comb begin
        n_res = r_sum - r_ab;
        if (r_sum < r_ab) begin
            n_res = n_res + i_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
        end else if (i_en) begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= n_sum;
            r_ab  <= i_ab;
            r_res <= n_res;
        end
    end

    assign o_ctl = r_ctl2;
    assign o_res = r_res;

endmodule

### hdl/beaver_triple_mod_multiply_unit.sv
// Pipeline from input transaction to result valid: one reduce cell and one
// multiply cell per operand bit, then two closing add/sub stages, the second
// being the output register.
// Throughput: one transaction per cycle; the whole chain holds while the
// output register is full and not taken. Reset clears the modulus
// registers and all valid flags; no clearing pass.
// ----------------------------------------------------------------------------
// beaver_triple_mod_multiply_unit: pipelined share product mod p
// Reduces x, a, c mod p, multiplies x*y and a*b mod p in a chain of cells,
// then returns (c + x*y - a*b) mod p. A zero modulus flags an error.
// ----------------------------------------------------------------------------
module beaver_triple_mod_multiply_unit
    import bt_pkg::*;
#(
    parameter int unsigned MOD_WIDTH = DEF_MOD_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [HALF_WIDTH-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [HALF_WIDTH-1:0] i_x_low,
    input  logic [HALF_WIDTH-1:0] i_x_high,
    input  logic [HALF_WIDTH-1:0] i_y_low,
    input  logic [HALF_WIDTH-1:0] i_y_high,
    input  logic [HALF_WIDTH-1:0] i_a_low,
    input  logic [HALF_WIDTH-1:0] i_a_high,
    input  logic [HALF_WIDTH-1:0] i_b_low,
    input  logic [HALF_WIDTH-1:0] i_b_high,
    input  logic [HALF_WIDTH-1:0] i_c_low,
    input  logic [HALF_WIDTH-1:0] i_c_high,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [HALF_WIDTH-1:0] o_product_low,
    output logic [HALF_WIDTH-1:0] o_product_high,
    output logic                  o_modulus_error
);

    localparam int unsigned NC = SRC_WIDTH;

    logic [HALF_WIDTH-1:0] r_mod_low;
    logic [HALF_WIDTH-1:0] r_mod_high;
    logic [SRC_WIDTH-1:0]  mod_full;
    logic [MOD_WIDTH-1:0]  p;
    logic                  en;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod_low  <= '0;
            r_mod_high <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MOD_LOW:  r_mod_low  <= i_cfg_data;
                REG_MOD_HIGH: r_mod_high <= i_cfg_data;
                default:      r_mod_low  <= r_mod_low;
            endcase
        end
    end

    assign mod_full = {r_mod_high, r_mod_low};
    assign p        = mod_full[MOD_WIDTH-1:0];

    // whole chain advances unless a result is waiting and not taken
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    // reduction chain
    t_ctl                      red_ctl  [NC+1];
    logic [2:0][SRC_WIDTH-1:0] red_src  [NC+1];
    logic [2:0][MOD_WIDTH-1:0] red_rem  [NC+1];
    logic [1:0][SRC_WIDTH-1:0] red_pass [NC+1];

    assign red_ctl[0]  = '{valid: i_valid, zero_mod: (p == '0)};
    assign red_src[0]  = {{i_c_high, i_c_low}, {i_a_high, i_a_low}, {i_x_high, i_x_low}};
    assign red_rem[0]  = '0;
    assign red_pass[0] = {{i_b_high, i_b_low}, {i_y_high, i_y_low}};

    for (genvar g = 0; g < NC; g++) begin : g_red
        bt_red_cell #(.MOD_WIDTH(MOD_WIDTH)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_p    (p),
            .i_ctl  (red_ctl[g]),
            .i_src  (red_src[g]),
            .i_rem  (red_rem[g]),
            .i_pass (red_pass[g]),
            .o_ctl  (red_ctl[g+1]),
            .o_src  (red_src[g+1]),
            .o_rem  (red_rem[g+1]),
            .o_pass (red_pass[g+1])
        );
    end

    // multiply chain: lane 0 = x*y, lane 1 = a*b
    t_ctl                      mul_ctl    [NC+1];
    logic [1:0][MOD_WIDTH-1:0] mul_mcand  [NC+1];
    logic [1:0][SRC_WIDTH-1:0] mul_mplier [NC+1];
    logic [1:0][MOD_WIDTH-1:0] mul_acc    [NC+1];
    logic [MOD_WIDTH-1:0]      mul_c      [NC+1];

    assign mul_ctl[0]    = red_ctl[NC];
    assign mul_mcand[0]  = {red_rem[NC][1], red_rem[NC][0]};
    assign mul_mplier[0] = red_pass[NC];
    assign mul_acc[0]    = '0;
    assign mul_c[0]      = red_rem[NC][2];

    for (genvar g = 0; g < NC; g++) begin : g_mul
        bt_mul_cell #(.MOD_WIDTH(MOD_WIDTH)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_p     (p),
            .i_ctl   (mul_ctl[g]),
            .i_mcand (mul_mcand[g]),
            .i_mplier(mul_mplier[g]),
            .i_acc   (mul_acc[g]),
            .i_c     (mul_c[g]),
            .o_ctl   (mul_ctl[g+1]),
            .o_mcand (mul_mcand[g+1]),
            .o_mplier(mul_mplier[g+1]),
            .o_acc   (mul_acc[g+1]),
            .o_c     (mul_c[g+1])
        );
    end

    // closing add/sub, last register is the output register
    t_ctl                 fin_ctl;
    logic [MOD_WIDTH-1:0] fin_res;
    logic [SRC_WIDTH-1:0] res_full;

    bt_final #(.MOD_WIDTH(MOD_WIDTH)) u_final (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_p    (p),
        .i_ctl  (mul_ctl[NC]),
        .i_c    (mul_c[NC]),
        .i_xy   (mul_acc[NC][0]),
        .i_ab   (mul_acc[NC][1]),
        .o_ctl  (fin_ctl),
        .o_res  (fin_res)
    );

    assign res_full = fin_ctl.zero_mod ? '0 : SRC_WIDTH'(fin_res);

    assign o_valid         = fin_ctl.valid;
    assign o_product_low   = res_full[HALF_WIDTH-1:0];
    assign o_product_high  = res_full[SRC_WIDTH-1:HALF_WIDTH];
    assign o_modulus_error = fin_ctl.zero_mod;

endmodule
